@@ rtl/audio_ring_writer_flow_control_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the audio ring writer
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_WRITER_FLOW_CONTROL_MACROS_SVH
`define AUDIO_RING_WRITER_FLOW_CONTROL_MACROS_SVH

// same-cycle implication
`define ARW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/arw_pkg.sv @@
// ----------------------------------------------------------------------------
// arw_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package arw_pkg;

  localparam int unsigned PS_W       = 13;
  localparam int unsigned RP_W       = 7;
  localparam int unsigned GP_W       = 6;
  localparam int unsigned PR_W       = PS_W + RP_W;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned SMP_NAR_W  = 8;
  localparam int unsigned RD_W       = 16;
  localparam int unsigned ADDR_OUT_W = 16;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned PH_W       = 2;

  // operations
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [ST_W-1:0] ST_RETRY    = 2'd1;
  localparam logic [ST_W-1:0] ST_STOPPED  = 2'd2;
  localparam logic [ST_W-1:0] ST_FINISHED = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_PACKETS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_PACKETS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES   = 2'd3;

  localparam logic [PS_W-1:0] PS_RST   = 13'd512;
  localparam logic [RP_W-1:0] RP_RST   = 7'd16;
  localparam logic [GP_W-1:0] GP_RST   = 6'd2;
  localparam logic            WIDE_RST = 1'b1;

  localparam logic [RP_W-1:0] RP_MIN = 7'd2;
  localparam logic [RP_W-1:0] RP_MAX = 7'd64;

  // end detector phases
  localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PH_W-1:0] PH_ARMED   = 2'd1;
  localparam logic [PH_W-1:0] PH_WRAPPED = 2'd2;

  typedef enum logic [1:0] {
    DIV_RING_PKTS,
    DIV_GUARD,
    DIV_WRITE_PKT,
    DIV_READ_PKT
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     load_prod;
    logic     load_rp;
    logic     load_gp;
    logic     load_ring;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_wpk;
    logic     load_lpk;
    logic     apply;
  } cmd_t;

  typedef struct packed {
    logic cfg_dirty;
    logic prod_over;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/arw_div.sv @@
// ----------------------------------------------------------------------------
// arw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arw_div #(
  parameter int unsigned W = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  dvs_q;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/arw_dp.sv @@
// ----------------------------------------------------------------------------
// arw_dp
// Datapath: config, ring geometry, end detector, write position, result reg.
// ----------------------------------------------------------------------------
module arw_dp #(
  parameter int unsigned RING_ADDR_BITS = 16,
  parameter int unsigned PACKET_BITS    = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arw_pkg::cmd_t                       cmd_i,
  output arw_pkg::sts_t                       sts_o,
  input  logic                                cfg_we_i,
  input  logic [arw_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [arw_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [arw_pkg::OP_W-1:0]            operation_i,
  input  logic signed [arw_pkg::SMP_W-1:0]    sample_in_i,
  input  logic [arw_pkg::RD_W-1:0]            read_position_i,
  input  logic                                stop_request_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [arw_pkg::ST_W-1:0]            status_o,
  output logic [arw_pkg::ADDR_OUT_W-1:0]      ring_address_o,
  output logic signed [arw_pkg::SMP_W-1:0]    sample_out_o,
  output logic                                packet_committed_o,
  output logic                                playing_o
);

  localparam int unsigned A  = RING_ADDR_BITS;
  localparam int unsigned VW = (A + 1 > 20) ? A + 1 : 20;
  localparam int unsigned LW = A + 1;
  localparam int unsigned FW = PACKET_BITS;
  localparam int PS_LIM = ((1 << PACKET_BITS) < (1 << (A - 1))) ?
                          (1 << PACKET_BITS) : (1 << (A - 1));
  localparam logic [VW-1:0] RING_MAX_V  = VW'(1) << A;
  localparam logic [VW-1:0] ADDR_MASK_V = RING_MAX_V - VW'(1);

  // configuration
  logic [arw_pkg::PS_W-1:0] pkt_q;
  logic [arw_pkg::RP_W-1:0] rpk_q;
  logic [arw_pkg::GP_W-1:0] guard_q;
  logic                     wide_q;
  logic                     dirty_q;

  // derived geometry
  logic [VW-1:0]            prod_q;
  logic [arw_pkg::RP_W-1:0] rp_q;
  logic [arw_pkg::GP_W-1:0] gp_q;
  logic [VW-1:0]            ring_q;
  logic [VW-1:0]            wpk_q;
  logic [VW-1:0]            lpk_q;

  // captured request
  logic [arw_pkg::OP_W-1:0]  op_q;
  logic [arw_pkg::SMP_W-1:0] smp_q;
  logic [arw_pkg::RD_W-1:0]  rd_q;
  logic                      stop_q;

  // block state
  logic [A-1:0]             wb_q,    wb_d;
  logic [FW-1:0]            fill_q,  fill_d;
  logic [arw_pkg::PH_W-1:0] phase_q, phase_d;
  logic [LW-1:0]            lim_q,   lim_d;
  logic [FW-1:0]            off_q,   off_d;
  logic [arw_pkg::RD_W-1:0] prev_q,  prev_d;
  logic                     run_q,   run_d;

  // result register
  logic                            out_valid_q;
  logic [arw_pkg::ST_W-1:0]        st_q,   st_d;
  logic [arw_pkg::ADDR_OUT_W-1:0]  addr_q, addr_d;
  logic [arw_pkg::SMP_W-1:0]       so_q,   so_d;
  logic                            com_q,  com_d;

  logic [arw_pkg::PS_W-1:0] ps_c;
  logic [arw_pkg::RP_W-1:0] rp_sat;
  logic [arw_pkg::RP_W-1:0] mul_b;
  logic [arw_pkg::PR_W-1:0] mul_p;
  logic                     prod_over;

  logic [VW-1:0] div_a, div_b, div_quot, div_rem;
  logic          div_done;

  logic [VW-1:0] half;
  logic [VW-1:0] prev_v, rd_v, lim_v;
  logic          wrapped;
  logic [arw_pkg::PH_W-1:0] phase_n;
  logic [LW-1:0] lim_n;
  logic [arw_pkg::RD_W-1:0] prev_n;
  logic          finish;

  logic [A-1:0]  wb_eff;
  logic [FW-1:0] fill_eff;
  logic [VW-1:0] fill_inc;
  logic          fill_last;
  logic [VW-1:0] addr_full;
  logic [VW-1:0] wb_sum;
  logic [arw_pkg::SMP_W-1:0] stored;

  logic [VW-1:0] guard_pk;
  logic          retry, pause;

  // ---------------------------------------------------------------- geometry
  always_comb begin
    if (pkt_q == '0) begin
      ps_c = arw_pkg::PS_W'(1);
    end else if (int'(pkt_q) > PS_LIM) begin
      ps_c = arw_pkg::PS_W'(PS_LIM);
    end else begin
      ps_c = pkt_q;
    end
    if (rpk_q < arw_pkg::RP_MIN) begin
      rp_sat = arw_pkg::RP_MIN;
    end else if (rpk_q > arw_pkg::RP_MAX) begin
      rp_sat = arw_pkg::RP_MAX;
    end else begin
      rp_sat = rpk_q;
    end
    mul_b     = cmd_i.load_prod ? rp_sat : rp_q;
    mul_p     = arw_pkg::PR_W'(ps_c) * arw_pkg::PR_W'(mul_b);
    prod_over = (prod_q > RING_MAX_V);
  end

  always_comb begin
    case (cmd_i.div_sel)
      arw_pkg::DIV_RING_PKTS: begin
        div_a = RING_MAX_V;
        div_b = VW'(ps_c);
      end
      arw_pkg::DIV_GUARD: begin
        div_a = VW'(guard_q);
        div_b = VW'(rp_q);
      end
      arw_pkg::DIV_WRITE_PKT: begin
        div_a = VW'(wb_eff);
        div_b = VW'(ps_c);
      end
      arw_pkg::DIV_READ_PKT: begin
        div_a = VW'(rd_q);
        div_b = VW'(ps_c);
      end
      default: begin
        div_a = '0;
        div_b = VW'(1);
      end
    endcase
  end

  arw_div #(
    .W (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ------------------------------------------------------------ end detector
  always_comb begin
    half    = ring_q >> 1;
    prev_v  = VW'(prev_q);
    rd_v    = VW'(rd_q);
    lim_v   = VW'(lim_q);
    wrapped = (prev_v >= half) && (rd_v < (prev_v - half));
    phase_n = phase_q;
    lim_n   = lim_q;
    prev_n  = prev_q;
    finish  = 1'b0;
    case (phase_q)
      arw_pkg::PH_IDLE: begin
      end
      arw_pkg::PH_ARMED: begin
        if ((rd_v < lim_v) || wrapped) begin
          phase_n = arw_pkg::PH_WRAPPED;
          lim_n   = LW'(lim_v + VW'(off_q));
        end
        prev_n = rd_q;
      end
      arw_pkg::PH_WRAPPED: begin
        finish = (rd_v >= lim_v) || wrapped;
        prev_n = rd_q;
      end
      default: begin
        prev_n = rd_q;
      end
    endcase
  end

  // ---------------------------------------------------------- write position
  always_comb begin
    wb_eff    = (VW'(wb_q) >= ring_q) ? '0 : wb_q;
    fill_eff  = (VW'(fill_q) >= VW'(ps_c)) ? '0 : fill_q;
    fill_inc  = VW'(fill_eff) + VW'(1);
    fill_last = (fill_inc >= VW'(ps_c));
    addr_full = (VW'(wb_eff) + VW'(fill_eff)) & ADDR_MASK_V;
    wb_sum    = VW'(wb_eff) + VW'(ps_c);
    stored    = wide_q ? smp_q
                       : {{(arw_pkg::SMP_W - arw_pkg::SMP_NAR_W){smp_q[arw_pkg::SMP_NAR_W-1]}},
                          smp_q[arw_pkg::SMP_NAR_W-1:0]};
    // packet the player must stay clear of
    guard_pk = (wpk_q >= VW'(gp_q)) ? (wpk_q - VW'(gp_q))
                                    : (wpk_q + VW'(rp_q) - VW'(gp_q));
    retry  = (lpk_q == wpk_q) && run_q;
    pause  = ((guard_pk < wpk_q) && (lpk_q >= guard_pk) && (lpk_q < wpk_q)) ||
             ((guard_pk > wpk_q) && ((lpk_q >= guard_pk) || (lpk_q < wpk_q)));
  end

  // ------------------------------------------------------------ step result
  always_comb begin
    wb_d    = wb_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    lim_d   = lim_q;
    off_d   = off_q;
    prev_d  = prev_q;
    run_d   = run_q;
    st_d    = arw_pkg::ST_ACCEPTED;
    addr_d  = '0;
    so_d    = '0;
    com_d   = 1'b0;
    case (op_q)
      arw_pkg::OP_SAMPLE: begin
        if (stop_q) begin
          run_d = 1'b0;
          st_d  = arw_pkg::ST_STOPPED;
        end else if (finish) begin
          run_d = 1'b0;
          st_d  = arw_pkg::ST_FINISHED;
        end else if (fill_last && retry) begin
          st_d = arw_pkg::ST_RETRY;
        end else begin
          phase_d = phase_n;
          lim_d   = lim_n;
          prev_d  = prev_n;
          addr_d  = addr_full[arw_pkg::ADDR_OUT_W-1:0];
          so_d    = stored;
          if (fill_last) begin
            com_d  = 1'b1;
            fill_d = '0;
            wb_d   = (wb_sum >= ring_q) ? '0 : wb_sum[A-1:0];
            if (pause) begin
              run_d = 1'b0;
            end else if (lpk_q != wpk_q) begin
              run_d = 1'b1;
            end
          end else begin
            wb_d   = wb_eff;
            fill_d = fill_inc[FW-1:0];
          end
        end
      end
      arw_pkg::OP_ARM: begin
        phase_d = arw_pkg::PH_ARMED;
        lim_d   = LW'(wb_q);
        off_d   = fill_q;
      end
      arw_pkg::OP_DISARM: begin
        phase_d = arw_pkg::PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q       <= arw_pkg::PS_RST;
      rpk_q       <= arw_pkg::RP_RST;
      guard_q     <= arw_pkg::GP_RST;
      wide_q      <= arw_pkg::WIDE_RST;
      dirty_q     <= 1'b1;
      wb_q        <= '0;
      fill_q      <= '0;
      phase_q     <= arw_pkg::PH_IDLE;
      lim_q       <= '0;
      off_q       <= '0;
      prev_q      <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
        case (cfg_addr_i)
          arw_pkg::CFG_PACKET_SAMPLES: pkt_q   <= cfg_wdata_i[arw_pkg::PS_W-1:0];
          arw_pkg::CFG_RING_PACKETS:   rpk_q   <= cfg_wdata_i[arw_pkg::RP_W-1:0];
          arw_pkg::CFG_GUARD_PACKETS:  guard_q <= cfg_wdata_i[arw_pkg::GP_W-1:0];
          arw_pkg::CFG_WIDE_SAMPLES:   wide_q  <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end else if (cmd_i.load_ring) begin
        dirty_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        wb_q        <= wb_d;
        fill_q      <= fill_d;
        phase_q     <= phase_d;
        lim_q       <= lim_d;
        off_q       <= off_d;
        prev_q      <= prev_d;
        run_q       <= run_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      smp_q  <= sample_in_i;
      rd_q   <= read_position_i;
      stop_q <= stop_request_i;
    end
    if (cmd_i.load_prod) begin
      prod_q <= VW'(mul_p);
    end
    if (cmd_i.load_rp) begin
      rp_q <= prod_over ? div_quot[arw_pkg::RP_W-1:0] : rp_sat;
    end
    if (cmd_i.load_gp) begin
      gp_q <= div_rem[arw_pkg::GP_W-1:0];
    end
    if (cmd_i.load_ring) begin
      ring_q <= VW'(mul_p);
    end
    if (cmd_i.load_wpk) begin
      wpk_q <= div_quot;
    end
    if (cmd_i.load_lpk) begin
      lpk_q <= div_quot;
    end
    if (cmd_i.apply) begin
      st_q   <= st_d;
      addr_q <= addr_d;
      so_q   <= so_d;
      com_q  <= com_d;
    end
  end

  always_comb begin
    sts_o.cfg_dirty = dirty_q;
    sts_o.prod_over = prod_over;
    sts_o.need_div  = (op_q == arw_pkg::OP_SAMPLE) && !stop_q && !finish && fill_last;
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = st_q;
  assign ring_address_o     = addr_q;
  assign sample_out_o       = so_q;
  assign packet_committed_o = com_q;
  assign playing_o          = run_q;

endmodule

@@ rtl/arw_ctrl.sv @@
// ----------------------------------------------------------------------------
// arw_ctrl
// Sequencer: geometry refresh, packet divisions and result hand-off.
// ----------------------------------------------------------------------------
module arw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  arw_pkg::sts_t sts_i,
  output arw_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_RP    = 4'd3;
  localparam logic [3:0] S_GP_GO = 4'd4;
  localparam logic [3:0] S_GP    = 4'd5;
  localparam logic [3:0] S_RING  = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_DIV_W = 4'd8;
  localparam logic [3:0] S_DIV_R = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_sel = arw_pkg::DIV_GUARD;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.cfg_dirty ? S_MUL : S_EVAL;
        end
      end
      S_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        // ring too large: packet count becomes ring capacity over packet size
        if (sts_i.prod_over) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = arw_pkg::DIV_RING_PKTS;
          state_d = S_RP;
        end else begin
          cmd_o.load_rp = 1'b1;
          state_d = S_GP_GO;
        end
      end
      S_RP: begin
        if (sts_i.div_done) begin
          cmd_o.load_rp = 1'b1;
          state_d = S_GP_GO;
        end
      end
      S_GP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = arw_pkg::DIV_GUARD;
        state_d = S_GP;
      end
      S_GP: begin
        if (sts_i.div_done) begin
          cmd_o.load_gp = 1'b1;
          state_d = S_RING;
        end
      end
      S_RING: begin
        cmd_o.load_ring = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = arw_pkg::DIV_WRITE_PKT;
          state_d = S_DIV_W;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV_W: begin
        cmd_o.div_sel = arw_pkg::DIV_READ_PKT;
        if (sts_i.div_done) begin
          cmd_o.load_wpk  = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (sts_i.div_done) begin
          cmd_o.load_lpk = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/audio_ring_writer_flow_control.sv @@
// ----------------------------------------------------------------------------
// audio_ring_writer_flow_control
// Ordinary request: captured on accept, evaluated, then the result is registered
// once the output is free; no new request is taken before that. Packet-ending sample:
// adds two divider runs (write and read position over packet size), divider width
// DW = max(RING_ADDR_BITS+1, 20). First request after reset or a config write adds a
// ring geometry refresh. Reset: config to defaults, positions zero, paused.
// ----------------------------------------------------------------------------
`include "audio_ring_writer_flow_control_macros.svh"

module audio_ring_writer_flow_control #(
  parameter int unsigned RING_ADDR_BITS = 16,
  parameter int unsigned PACKET_BITS    = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [arw_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [arw_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [arw_pkg::OP_W-1:0]         operation_i,
  input  logic signed [arw_pkg::SMP_W-1:0] sample_in_i,
  input  logic [arw_pkg::RD_W-1:0]         read_position_i,
  input  logic                             stop_request_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [arw_pkg::ST_W-1:0]         status_o,
  output logic [arw_pkg::ADDR_OUT_W-1:0]   ring_address_o,
  output logic signed [arw_pkg::SMP_W-1:0] sample_out_o,
  output logic                             packet_committed_o,
  output logic                             playing_o
);

  arw_pkg::cmd_t cmd;
  arw_pkg::sts_t sts;

  arw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arw_dp #(
    .RING_ADDR_BITS (RING_ADDR_BITS),
    .PACKET_BITS    (PACKET_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .operation_i        (operation_i),
    .sample_in_i        (sample_in_i),
    .read_position_i    (read_position_i),
    .stop_request_i     (stop_request_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .status_o           (status_o),
    .ring_address_o     (ring_address_o),
    .sample_out_o       (sample_out_o),
    .packet_committed_o (packet_committed_o),
    .playing_o          (playing_o)
  );

  // one request in flight
  `ARW_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                   "second request taken while busy")
  // a result is never overwritten before it is taken
  `ARW_ASSERT_SAME(a_no_overwrite, cmd.apply, !out_valid_o || out_ready_i,
                   "pending result overwritten")
  `ARW_ASSERT_SAME(a_halt_clears_run,
                   out_valid_o && (status_o == arw_pkg::ST_STOPPED ||
                                   status_o == arw_pkg::ST_FINISHED),
                   !playing_o, "player still running after stop or finish")
  `ARW_ASSERT_SAME(a_refused_is_empty, out_valid_o && status_o != arw_pkg::ST_ACCEPTED,
                   ring_address_o == '0 && !packet_committed_o,
                   "non-accepted result carries a slot")

endmodule
